FILE: hdl/cbag_pkg.sv
// ----------------------------------------------------------------------------
// cbag_pkg
// Shared types and constants for the clipped blit address generator.
// ----------------------------------------------------------------------------
package cbag_pkg;

  // largest source or surface dimension and largest row pitch
  localparam logic [12:0] MAX_DIM   = 13'd4096;
  localparam logic [13:0] MAX_PITCH = 14'd8192;

  // item kinds carried in tuser
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_ARGS    = 2'd1,
    ST_NOT_VISIBLE = 2'd2,
    ST_IDLE_STEP   = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SURFACE_WIDTH  = 2'd0,
    REG_SURFACE_HEIGHT = 2'd1,
    REG_SURFACE_STRIDE = 2'd2
  } reg_idx_e;

  // start item fields
  typedef struct packed {
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic [13:0] rect_pitch;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
  } start_args_t;

  // surface geometry after clamping
  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [13:0] pitch;
  } surface_t;

  // outcome of a start item, also the walker load
  typedef struct packed {
    status_e     status;
    logic        load;
    logic [11:0] clip_x;
    logic [11:0] clip_y;
    logic [12:0] clip_width;
    logic [12:0] clip_height;
    logic [24:0] src_base;
    logic [24:0] dst_base;
    logic [13:0] src_pitch;
  } start_res_t;

  // outcome of a step item
  typedef struct packed {
    status_e     status;
    logic [24:0] source_index;
    logic [24:0] dest_index;
    logic        last;
  } step_res_t;

endpackage

FILE: hdl/cbag_clip.sv
// ----------------------------------------------------------------------------
// cbag_clip
// Checks start arguments, clips the source rectangle against the surface and
// works out the first source and destination row offsets.
// ----------------------------------------------------------------------------
module cbag_clip
  import cbag_pkg::*;
(
  input  start_args_t args_i,
  input  surface_t    surf_i,
  output start_res_t  res_o
);

  logic        bad_args;
  logic        dx_neg;
  logic        dy_neg;
  logic [15:0] src_x;
  logic [15:0] src_y;
  logic [14:0] dst_x;
  logic [14:0] dst_y;
  logic [18:0] cw_raw;
  logic [18:0] cw_room;
  logic [18:0] cw_clip;
  logic [18:0] ch_raw;
  logic [18:0] ch_room;
  logic [18:0] ch_clip;
  logic        visible;
  logic [29:0] src_prod;
  logic [25:0] dst_prod;

  // argument check
  assign bad_args = (args_i.rect_width == '0) || (args_i.rect_height == '0) ||
                    (args_i.rect_width > MAX_DIM) || (args_i.rect_height > MAX_DIM) ||
                    (args_i.rect_pitch > MAX_PITCH) ||
                    (args_i.rect_pitch < {1'b0, args_i.rect_width});

  // split negative positions into a source offset
  assign dx_neg = args_i.dest_x[15];
  assign dy_neg = args_i.dest_y[15];
  assign src_x  = dx_neg ? 16'(-args_i.dest_x) : 16'd0;
  assign src_y  = dy_neg ? 16'(-args_i.dest_y) : 16'd0;
  assign dst_x  = dx_neg ? 15'd0 : args_i.dest_x[14:0];
  assign dst_y  = dy_neg ? 15'd0 : args_i.dest_y[14:0];

  // clip against the left/top edge, then against the right/bottom edge
  assign cw_raw  = {6'd0, args_i.rect_width} - {3'd0, src_x};
  assign ch_raw  = {6'd0, args_i.rect_height} - {3'd0, src_y};
  assign cw_room = {6'd0, surf_i.width} - {4'd0, dst_x};
  assign ch_room = {6'd0, surf_i.height} - {4'd0, dst_y};
  assign cw_clip = ($signed(cw_raw) > $signed(cw_room)) ? cw_room : cw_raw;
  assign ch_clip = ($signed(ch_raw) > $signed(ch_room)) ? ch_room : ch_raw;
  assign visible = !cw_clip[18] && (cw_clip != '0) && !ch_clip[18] && (ch_clip != '0);

  // first row offsets, only kept when something is visible
  assign src_prod = src_y * args_i.rect_pitch;
  assign dst_prod = dst_y[11:0] * surf_i.pitch;

  // result assembly
  always_comb begin
    res_o = '0;
    res_o.status = ST_OK;
    if (bad_args) begin
      res_o.status = ST_BAD_ARGS;
    end else if (!visible) begin
      res_o.status = ST_NOT_VISIBLE;
    end else begin
      res_o.load        = 1'b1;
      res_o.clip_x      = dst_x[11:0];
      res_o.clip_y      = dst_y[11:0];
      res_o.clip_width  = cw_clip[12:0];
      res_o.clip_height = ch_clip[12:0];
      res_o.src_base    = src_prod[24:0] + {9'd0, src_x};
      res_o.dst_base    = dst_prod[24:0] + {13'd0, dst_x[11:0]};
      res_o.src_pitch   = args_i.rect_pitch;
    end
  end

endmodule

FILE: hdl/cbag_walker.sv
// ----------------------------------------------------------------------------
// cbag_walker
// Raster walk state: column and row counters plus row base offsets, giving
// one source/destination offset pair per step.
// ----------------------------------------------------------------------------
module cbag_walker
  import cbag_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  start_res_t  start_res_i,
  input  logic        step_i,
  input  logic [13:0] dest_pitch_i,
  output step_res_t   res_o
);

  logic        active_q,   active_d;
  logic [11:0] col_q,      col_d;
  logic [11:0] row_q,      row_d;
  logic [12:0] cols_q,     cols_d;
  logic [12:0] rows_q,     rows_d;
  logic [24:0] src_base_q, src_base_d;
  logic [24:0] dst_base_q, dst_base_d;
  logic [13:0] pitch_q,    pitch_d;
  logic        final_col;
  logic        final_row;

  assign final_col = ({1'b0, col_q} + 13'd1) >= cols_q;
  assign final_row = ({1'b0, row_q} + 13'd1) >= rows_q;

  // step result
  always_comb begin
    res_o = '0;
    if (!active_q) begin
      res_o.status = ST_IDLE_STEP;
    end else begin
      res_o.status       = ST_OK;
      res_o.source_index = src_base_q + {13'd0, col_q};
      res_o.dest_index   = dst_base_q + {13'd0, col_q};
      res_o.last         = final_col && final_row;
    end
  end

  // next state
  always_comb begin
    active_d   = active_q;
    col_d      = col_q;
    row_d      = row_q;
    cols_d     = cols_q;
    rows_d     = rows_q;
    src_base_d = src_base_q;
    dst_base_d = dst_base_q;
    pitch_d    = pitch_q;
    if (start_i) begin
      active_d = start_res_i.load;
      if (start_res_i.load) begin
        col_d      = '0;
        row_d      = '0;
        cols_d     = start_res_i.clip_width;
        rows_d     = start_res_i.clip_height;
        src_base_d = start_res_i.src_base;
        dst_base_d = start_res_i.dst_base;
        pitch_d    = start_res_i.src_pitch;
      end
    end else if (step_i && active_q) begin
      if (final_col) begin
        col_d = '0;
        if (final_row) begin
          active_d = 1'b0;
          row_d    = '0;
        end else begin
          row_d      = row_q + 12'd1;
          src_base_d = src_base_q + {11'd0, pitch_q};
          dst_base_d = dst_base_q + {11'd0, dest_pitch_i};
        end
      end else begin
        col_d = col_q + 12'd1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      cols_q     <= '0;
      rows_q     <= '0;
      src_base_q <= '0;
      dst_base_q <= '0;
      pitch_q    <= '0;
    end else begin
      active_q   <= active_d;
      col_q      <= col_d;
      row_q      <= row_d;
      cols_q     <= cols_d;
      rows_q     <= rows_d;
      src_base_q <= src_base_d;
      dst_base_q <= dst_base_d;
      pitch_q    <= pitch_d;
    end
  end

endmodule

FILE: hdl/clipped_blit_address_generator_unit.sv
// Pipeline: an accepted item passes through the input register, then the result
// register, before its result is presented.
// Throughput: one item per cycle, start or step, while the output is not stalled; the
// next walk counters and row base sums are combinational, so a step may follow a start directly.
// Reset: asynchronous, active low; clears the walk state (no blit active),
// empties both stages and sets the surface registers to width, height and
// stride 1.
// ----------------------------------------------------------------------------
// clipped_blit_address_generator_unit
// Clipped rectangle blit address generator: input register, clip and walk
// logic, output register.
// ----------------------------------------------------------------------------
module clipped_blit_address_generator_unit
  import cbag_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [13:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rectangle width, rectangle height, rectangle pitch, dest_x, dest_y
  input  logic [71:0]  s_axis_tdata,
  // cmd
  input  logic [0:0]   s_axis_tuser,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, clip_x, clip_y, clip_width, clip_height, source_index,
  // dest_index, two zero bits
  output logic [103:0] m_axis_tdata,
  // last
  output logic         m_axis_tlast
);

  logic [12:0]  surf_w_q;
  logic [12:0]  surf_h_q;
  logic [13:0]  surf_s_q;
  surface_t     surf;

  logic         in_valid_q;
  cmd_e         in_cmd_q;
  start_args_t  in_args_q;

  logic         out_valid_q;
  logic [103:0] out_data_q, out_data_d;
  logic         out_last_q, out_last_d;

  logic         out_free;
  logic         advance;
  logic         in_take;
  start_res_t   start_res;
  step_res_t    step_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_w_q <= 13'd1;
      surf_h_q <= 13'd1;
      surf_s_q <= 14'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SURFACE_WIDTH:  surf_w_q <= cfg_data_i[12:0];
        REG_SURFACE_HEIGHT: surf_h_q <= cfg_data_i[12:0];
        REG_SURFACE_STRIDE: surf_s_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp surface geometry to the supported limits
  assign surf.width  = (surf_w_q > MAX_DIM) ? MAX_DIM : surf_w_q;
  assign surf.height = (surf_h_q > MAX_DIM) ? MAX_DIM : surf_h_q;
  assign surf.pitch  = (surf_s_q > MAX_PITCH) ? MAX_PITCH : surf_s_q;

  // handshake between the two stages
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q              <= cmd_e'(s_axis_tuser[0]);
      in_args_q.rect_width  <= s_axis_tdata[12:0];
      in_args_q.rect_height <= s_axis_tdata[25:13];
      in_args_q.rect_pitch  <= s_axis_tdata[39:26];
      in_args_q.dest_x      <= s_axis_tdata[55:40];
      in_args_q.dest_y      <= s_axis_tdata[71:56];
    end
  end

  // start handling
  cbag_clip u_clip (
    .args_i (in_args_q),
    .surf_i (surf),
    .res_o  (start_res)
  );

  // raster walk
  cbag_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (advance && (in_cmd_q == CMD_START)),
    .start_res_i  (start_res),
    .step_i       (advance && (in_cmd_q == CMD_STEP)),
    .dest_pitch_i (surf.pitch),
    .res_o        (step_res)
  );

  // result selection
  always_comb begin
    unique case (in_cmd_q)
      CMD_START: begin
        out_data_d = {2'b00, 25'd0, 25'd0, start_res.clip_height, start_res.clip_width,
                      start_res.clip_y, start_res.clip_x, start_res.status};
        out_last_d = 1'b0;
      end
      CMD_STEP: begin
        out_data_d = {2'b00, step_res.dest_index, step_res.source_index, 50'd0,
                      step_res.status};
        out_last_d = step_res.last;
      end
      default: begin
        out_data_d = '0;
        out_last_d = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: hdl/cbag_checker.sv
// ----------------------------------------------------------------------------
// cbag_checker
// Port-level checks for the clipped blit address generator.
// ----------------------------------------------------------------------------
module cbag_checker
  import cbag_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a new result rises only after an accepted input transaction
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without input transaction");

  // last pair is always a good step
  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == ST_OK)
    else $error("last on a failing result");

  // failing results carry no offsets
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK)
      |-> (m_axis_tdata[103:52] == '0) && !m_axis_tlast)
    else $error("offsets on a failing result");

  // a start result with clip data carries no offsets
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[38:26] != '0) |-> m_axis_tdata[103:52] == '0)
    else $error("offsets on a start result");

endmodule

bind clipped_blit_address_generator_unit cbag_checker u_cbag_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: test/tb_clipped_blit_address_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_clipped_blit_address_generator_unit
// Self-checking bench for the clipped blit address generator: directed start
// and step sequences cover argument rejection, clipping on every edge, aborted
// blits, register extremes and a pitch change during a walk. Random blits run
// under several sender and receiver idling mixes. A local predictor computes
// every result and a checker compares each output transaction with it.
// ----------------------------------------------------------------------------
module tb_clipped_blit_address_generator_unit;
  import cbag_pkg::*;

  localparam int          RESET_CYCLES = 6;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          MAX_REPORTS  = 10;
  localparam int          TAIL_CYCLES  = 8;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  // one result as seen on the output stream
  typedef struct packed {
    status_e     status;
    logic [11:0] clip_x;
    logic [11:0] clip_y;
    logic [12:0] clip_width;
    logic [12:0] clip_height;
    logic [24:0] source_index;
    logic [24:0] dest_index;
    logic        last;
  } blit_result_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [1:0]   cfg_addr_i    = '0;
  logic [13:0]  cfg_data_i    = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // rectangle width, rectangle height, rectangle pitch, dest_x, dest_y
  logic [71:0]  s_axis_tdata  = '0;
  // cmd
  logic [0:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // status, clip_x, clip_y, clip_width, clip_height, source_index,
  // dest_index, two zero bits
  logic [103:0] m_axis_tdata;
  // last
  logic         m_axis_tlast;

  clipped_blit_address_generator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // surface registers as the block should hold them
  logic [12:0]  surf_width;
  logic [12:0]  surf_height;
  logic [13:0]  surf_stride;

  // walk state of the predicted blit
  logic         blit_active;
  logic [11:0]  col_cnt;
  logic [11:0]  row_cnt;
  logic [12:0]  copy_cols;
  logic [12:0]  copy_rows;
  logic [24:0]  src_row_base;
  logic [24:0]  dst_row_base;
  logic [13:0]  src_pitch;

  blit_result_t pending_results[$];
  int           items_sent     = 0;
  int           fail_count     = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // expected result of one accepted item, advances the predicted walk
  function automatic blit_result_t predict_blit_item(cmd_e cmd, logic [71:0] args);
    blit_result_t res;
    logic [12:0]  sw;
    logic [12:0]  sh;
    logic [13:0]  sp;
    int           x;
    int           y;
    int           skip_x;
    int           skip_y;
    int           cw;
    int           ch;
    int           surf_w;
    int           surf_h;
    int           dpitch;
    int           base;
    logic         final_col;
    logic         final_row;
    res    = '0;
    surf_w = (surf_width > MAX_DIM) ? int'(MAX_DIM) : int'(surf_width);
    surf_h = (surf_height > MAX_DIM) ? int'(MAX_DIM) : int'(surf_height);
    dpitch = (surf_stride > MAX_PITCH) ? int'(MAX_PITCH) : int'(surf_stride);
    if (cmd == CMD_START) begin
      sw          = args[12:0];
      sh          = args[25:13];
      sp          = args[39:26];
      x           = int'($signed(args[55:40]));
      y           = int'($signed(args[71:56]));
      skip_x      = 0;
      skip_y      = 0;
      blit_active = 1'b0;
      if (sw == 0 || sh == 0 || sw > MAX_DIM || sh > MAX_DIM ||
          sp > MAX_PITCH || sp < sw) begin
        res.status = ST_BAD_ARGS;
      end else begin
        cw = int'(sw);
        ch = int'(sh);
        // clip left and top, then right and bottom
        if (x < 0) begin
          skip_x = -x;
          cw     = cw - skip_x;
          x      = 0;
        end
        if (y < 0) begin
          skip_y = -y;
          ch     = ch - skip_y;
          y      = 0;
        end
        if (x + cw > surf_w) cw = surf_w - x;
        if (y + ch > surf_h) ch = surf_h - y;
        if (cw <= 0 || ch <= 0) begin
          res.status = ST_NOT_VISIBLE;
        end else begin
          blit_active     = 1'b1;
          col_cnt         = '0;
          row_cnt         = '0;
          copy_cols       = cw[12:0];
          copy_rows       = ch[12:0];
          src_pitch       = sp;
          base            = skip_y * int'(sp) + skip_x;
          src_row_base    = base[24:0];
          base            = y * dpitch + x;
          dst_row_base    = base[24:0];
          res.status      = ST_OK;
          res.clip_x      = x[11:0];
          res.clip_y      = y[11:0];
          res.clip_width  = cw[12:0];
          res.clip_height = ch[12:0];
        end
      end
    end else if (!blit_active) begin
      res.status = ST_IDLE_STEP;
    end else begin
      final_col        = (int'(col_cnt) + 1 >= int'(copy_cols));
      final_row        = (int'(row_cnt) + 1 >= int'(copy_rows));
      res.status       = ST_OK;
      res.source_index = src_row_base + {13'd0, col_cnt};
      res.dest_index   = dst_row_base + {13'd0, col_cnt};
      res.last         = final_col && final_row;
      // surface pitch is read again on every row change
      if (final_col) begin
        col_cnt = '0;
        if (final_row) begin
          blit_active = 1'b0;
          row_cnt     = '0;
        end else begin
          row_cnt      = row_cnt + 12'd1;
          src_row_base = src_row_base + {11'd0, src_pitch};
          dst_row_base = dst_row_base + dpitch[24:0];
        end
      end else begin
        col_cnt = col_cnt + 12'd1;
      end
    end
    return res;
  endfunction

  // count a failure and print the first few
  task automatic report_failure(string what, blit_result_t exp_res, blit_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s: expected st %0d clip %0d,%0d %0dx%0d idx %0h/%0h last %0b",
               what, exp_res.status, exp_res.clip_x, exp_res.clip_y,
               exp_res.clip_width, exp_res.clip_height, exp_res.source_index,
               exp_res.dest_index, exp_res.last);
      $display("  got st %0d clip %0d,%0d %0dx%0d idx %0h/%0h last %0b",
               got.status, got.clip_x, got.clip_y, got.clip_width,
               got.clip_height, got.source_index, got.dest_index, got.last);
    end
  endtask

  // output side: random stalls and result checking
  always @(posedge clk_i) begin : check_results
    blit_result_t got;
    blit_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status       = status_e'(m_axis_tdata[1:0]);
      got.clip_x       = m_axis_tdata[13:2];
      got.clip_y       = m_axis_tdata[25:14];
      got.clip_width   = m_axis_tdata[38:26];
      got.clip_height  = m_axis_tdata[51:39];
      got.source_index = m_axis_tdata[76:52];
      got.dest_index   = m_axis_tdata[101:77];
      got.last         = m_axis_tlast;
      if (pending_results.size() == 0) begin
        report_failure("unexpected result", '0, got);
      end else begin
        exp_res = pending_results.pop_front();
        if (got.status !== exp_res.status || got.clip_x !== exp_res.clip_x ||
            got.clip_y !== exp_res.clip_y || got.clip_width !== exp_res.clip_width ||
            got.clip_height !== exp_res.clip_height ||
            got.source_index !== exp_res.source_index ||
            got.dest_index !== exp_res.dest_index || got.last !== exp_res.last) begin
          report_failure("mismatch", exp_res, got);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(cmd_e cmd, logic [71:0] args);
    blit_result_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= args;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_res = predict_blit_item(cmd, args);
    pending_results.push_back(exp_res);
    items_sent++;
  endtask

  task automatic send_start(logic [12:0] sw, logic [12:0] sh, logic [13:0] sp,
                            logic [15:0] x, logic [15:0] y);
    send_item(CMD_START, {y, x, sp, sh, sw});
  endtask

  function automatic logic [71:0] random_args();
    logic [95:0] bits;
    bits = {$urandom(), $urandom(), $urandom()};
    return bits[71:0];
  endfunction

  // step items carry random data that the block must ignore
  task automatic send_steps(int count);
    repeat (count) send_item(CMD_STEP, random_args());
  endtask

  // hold the input until every expected result has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // register write, only with nothing in flight
  task automatic write_surface_reg(logic [1:0] idx, logic [13:0] value);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_SURFACE_WIDTH:  surf_width  = value[12:0];
      REG_SURFACE_HEIGHT: surf_height = value[12:0];
      REG_SURFACE_STRIDE: surf_stride = value;
      default: ;
    endcase
  endtask

  task automatic test_step_while_idle();
    send_steps(1);
  endtask

  task automatic test_bad_arguments();
    send_start(13'd0, 13'd1, 14'd1, 16'd0, 16'd0);
    send_start(13'd1, 13'd0, 14'd1, 16'd0, 16'd0);
    send_start(13'd4097, 13'd1, 14'd8192, 16'd0, 16'd0);
    send_start(13'd1, 13'd4097, 14'd1, 16'd0, 16'd0);
    send_start(13'd1, 13'd1, 14'd8193, 16'd0, 16'd0);
    send_start(13'd5, 13'd1, 14'd4, 16'd0, 16'd0);
  endtask

  task automatic test_clipping();
    write_surface_reg(REG_SURFACE_WIDTH, 14'd8);
    write_surface_reg(REG_SURFACE_HEIGHT, 14'd6);
    write_surface_reg(REG_SURFACE_STRIDE, 14'd10);
    // top left clip, full walk
    send_start(13'd3, 13'd2, 14'd5, -16'sd1, -16'sd1);
    send_steps(2);
    // bottom right clip, abandoned halfway by an invisible start
    send_start(13'd4, 13'd3, 14'd4, 16'd6, 16'd4);
    send_steps(2);
    send_start(13'd4, 13'd1, 14'd4, 16'd8, 16'd0);
    send_steps(1);
    send_start(13'd4, 13'd1, 14'd4, -16'sd4, 16'd0);
    send_start(13'd1, 13'd1, 14'd1, 16'h8000, 16'h7fff);
  endtask

  task automatic test_large_geometry();
    write_surface_reg(REG_SURFACE_WIDTH, 14'd4096);
    write_surface_reg(REG_SURFACE_HEIGHT, 14'd4096);
    write_surface_reg(REG_SURFACE_STRIDE, 14'd8192);
    send_start(13'd4096, 13'd4096, 14'd8192, -16'sd4000, -16'sd4000);
    send_steps(1);
    send_start(13'd200, 13'd2, 14'd200, 16'd4000, 16'd4094);
    send_steps(1);
  endtask

  task automatic test_pitch_change_mid_blit();
    write_surface_reg(REG_SURFACE_WIDTH, 14'd8);
    write_surface_reg(REG_SURFACE_HEIGHT, 14'd8);
    write_surface_reg(REG_SURFACE_STRIDE, 14'd8);
    send_start(13'd2, 13'd2, 14'd2, 16'd1, 16'd1);
    send_steps(1);
    write_surface_reg(REG_SURFACE_STRIDE, 14'd20);
    send_steps(3);
  endtask

  task automatic test_register_extremes();
    write_surface_reg(REG_SURFACE_WIDTH, 14'd0);
    send_start(13'd1, 13'd1, 14'd1, 16'd0, 16'd0);
    write_surface_reg(REG_SURFACE_WIDTH, 14'd8191);
    write_surface_reg(REG_SURFACE_HEIGHT, 14'd1);
    write_surface_reg(REG_SURFACE_STRIDE, 14'd16383);
    write_surface_reg(REG_UNUSED, 14'h3fff);
    send_start(13'd1, 13'd1, 14'd1, 16'd4095, 16'd0);
    send_steps(1);
  endtask

  // random blits against one surface setting and one idling mix
  task automatic run_random_phase(int send_pct, int recv_pct, int item_target,
                                  logic [13:0] w, logic [13:0] h, logic [13:0] stride);
    int          first_item;
    int          choice;
    int          total;
    int          count;
    int          surf_w;
    int          surf_h;
    int          x;
    int          y;
    logic [12:0] sw;
    logic [12:0] sh;
    logic [13:0] sp;
    write_surface_reg(REG_SURFACE_WIDTH, w);
    write_surface_reg(REG_SURFACE_HEIGHT, h);
    write_surface_reg(REG_SURFACE_STRIDE, stride);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    surf_w     = (surf_width > MAX_DIM) ? int'(MAX_DIM) : int'(surf_width);
    surf_h     = (surf_height > MAX_DIM) ? int'(MAX_DIM) : int'(surf_height);
    first_item = items_sent;
    while (items_sent - first_item < item_target) begin
      choice = $urandom_range(99);
      if (choice < 70) begin
        // well-formed blit near the surface, mostly walked to the end
        sw = ($urandom_range(15) == 0) ? 13'($urandom_range(1, 4096))
                                       : 13'($urandom_range(1, 8));
        sh = ($urandom_range(15) == 0) ? 13'($urandom_range(1, 4096))
                                       : 13'($urandom_range(1, 6));
        sp = {1'b0, sw} + (($urandom_range(3) == 0) ? 14'($urandom_range(0, 8192 - sw))
                                                    : 14'($urandom_range(0, 3)));
        x  = int'($urandom_range(0, surf_w + sw)) - int'(sw);
        y  = int'($urandom_range(0, surf_h + sh)) - int'(sh);
        if ($urandom_range(19) == 0) x = int'($urandom_range(65535));
        if ($urandom_range(19) == 0) y = int'($urandom_range(65535));
        send_start(sw, sh, sp, x[15:0], y[15:0]);
        if (blit_active) begin
          total = int'(copy_cols) * int'(copy_rows);
          count = (total > 40) ? int'($urandom_range(1, 40)) : total;
          if ($urandom_range(7) == 0) count = $urandom_range(0, count);
          send_steps(count);
        end
        if ($urandom_range(9) == 0) send_steps(1);
      end else if (choice < 85) begin
        send_item(CMD_START, random_args());
      end else if (choice < 97) begin
        send_steps(1);
      end else begin
        drain_results();
      end
    end
    drain_results();
  endtask

  // test sequence
  initial begin
    surf_width   = 13'd1;
    surf_height  = 13'd1;
    surf_stride  = 14'd1;
    blit_active  = 1'b0;
    col_cnt      = '0;
    row_cnt      = '0;
    copy_cols    = '0;
    copy_rows    = '0;
    src_row_base = '0;
    dst_row_base = '0;
    src_pitch    = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_step_while_idle();
    test_bad_arguments();
    test_clipping();
    test_large_geometry();
    test_pitch_change_mid_blit();
    test_register_extremes();

    run_random_phase(0, 0, 125, 14'd12, 14'd9, 14'd16);
    run_random_phase(48, 0, 125, 14'd4096, 14'd4096, 14'd8192);
    run_random_phase(0, 48, 125, 14'd1, 14'd1, 14'd1);
    run_random_phase(25, 25, 125, 14'd8191, 14'd6000, 14'd16383);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
